// ----- src/bvcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bvcc_pkg
// Shared types, widths and the quarter-wave sine table for the box view
// cone cull block.
// ----------------------------------------------------------------------------
package bvcc_pkg;

    // angle and trig precision
    localparam int ANGLE_BITS     = 10;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W     = ANGLE_BITS - 1;
    localparam int SIN_MAG_W = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W    = TRIG_FRAC_BITS + 2;

    // coordinate arithmetic widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int CROSS_W = PROD_W + 1;

    // configuration register
    localparam int          HFOV_W         = 8;
    localparam logic [7:0]  HALF_FOV_RESET = 8'd64;

    // pi/2 in Q30
    localparam longint unsigned PIH_Q30 = 64'd1686629713;

    // one input item
    typedef struct packed {
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_right;
        logic signed [COORD_W-1:0] box_top;
        logic signed [COORD_W-1:0] box_bottom;
        logic signed [COORD_W-1:0] view_x;
        logic signed [COORD_W-1:0] view_y;
        logic [9:0]                view_angle;
    } item_t;

    // one result item
    typedef struct packed {
        logic visible;
        logic viewer_inside;
    } result_t;

    typedef logic [SIN_MAG_W-1:0] sin_tab_t [0:QUARTER];

    // truncating unsigned quotient by shift and subtract, table build only
    function automatic longint unsigned udiv_u64(
        input longint unsigned n,
        input longint unsigned d
    );
        longint unsigned q;
        longint unsigned rem;
        int              i;
        q   = 64'd0;
        rem = 64'd0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], n[i]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave sine magnitudes, Taylor series to the x^13 term in Q30,
    // rounded half up and capped at 1.0
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t          tab;
        longint unsigned   x;
        longint unsigned   term;
        longint unsigned   res;
        longint            sum;
        int                r;
        int                k;
        for (r = 0; r <= QUARTER; r++)
        begin
            x    = (longint'(r) * PIH_Q30) >> (ANGLE_BITS - 2);
            term = x;
            sum  = longint'(x);
            for (k = 1; k <= 6; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = udiv_u64(term, longint'((2 * k) * (2 * k + 1)));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            res = (longint'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                  >> (30 - TRIG_FRAC_BITS);
            if (res > (64'd1 << TRIG_FRAC_BITS))
                res = 64'd1 << TRIG_FRAC_BITS;
            tab[r] = SIN_MAG_W'(res);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ----- src/bvcc_sincos.sv -----
// ----------------------------------------------------------------------------
// bvcc_sincos
// Sine and cosine of a binary angle in Q1.TRIG_FRAC_BITS, by quadrant
// folding into the shared quarter-wave table.
// ----------------------------------------------------------------------------
module bvcc_sincos (
    input  logic [bvcc_pkg::ANGLE_BITS-1:0]     angle,
    output logic signed [bvcc_pkg::TRIG_W-1:0]  sin_val,
    output logic signed [bvcc_pkg::TRIG_W-1:0]  cos_val
);

    // fold to one quadrant, look up, restore sign
    function automatic logic signed [bvcc_pkg::TRIG_W-1:0] fold_sin(
        input logic [bvcc_pkg::ANGLE_BITS-1:0] a
    );
        logic [1:0]                          quad;
        logic [bvcc_pkg::IDX_W-1:0]          r;
        logic [bvcc_pkg::IDX_W-1:0]          idx;
        logic signed [bvcc_pkg::TRIG_W-1:0]  m;
        quad = a[bvcc_pkg::ANGLE_BITS-1 -: 2];
        r    = bvcc_pkg::IDX_W'(a[bvcc_pkg::ANGLE_BITS-3:0]);
        idx  = quad[0] ? (bvcc_pkg::IDX_W'(bvcc_pkg::QUARTER) - r) : r;
        m    = signed'({1'b0, bvcc_pkg::SIN_TAB[idx]});
        return quad[1] ? -m : m;
    endfunction

    logic [bvcc_pkg::ANGLE_BITS-1:0] cos_angle;

    // cosine is sine a quarter turn ahead
    assign cos_angle = angle + bvcc_pkg::ANGLE_BITS'(bvcc_pkg::QUARTER);

    assign sin_val = fold_sin(angle);
    assign cos_val = fold_sin(cos_angle);

endmodule

// ----- src/box_view_cone_cull.sv -----
// ----------------------------------------------------------------------------
// box_view_cone_cull
// View-cone visibility test of an axis-aligned box against a viewer
// position, view angle and programmable half field of view.
// ----------------------------------------------------------------------------
// A new box is taken on every cycle that start is high; busy stays low, so
// the block sustains one box per clock. Each box gives exactly one result,
// shown on result with done high for one cycle. Before that the box passes
// through offset and inside test, table lookup of both edge directions,
// eight cross-product multiplies, then sign tests. The receiver cannot hold
// results off and none is needed: results leave in input order at the rate
// boxes arrive. half_fov is written through cfg_valid/cfg_data (cfg_ready is
// always high) and should only change while no box is in flight.
module box_view_cone_cull (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bvcc_pkg::item_t              item,
    output logic                         done,
    output bvcc_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bvcc_pkg::HFOV_W-1:0]  cfg_data
);

    localparam int AB = bvcc_pkg::ANGLE_BITS;
    localparam int DW = bvcc_pkg::DIFF_W;
    localparam int TW = bvcc_pkg::TRIG_W;
    localparam int PW = bvcc_pkg::PROD_W;
    localparam int CW = bvcc_pkg::CROSS_W;

    // configuration register
    logic [bvcc_pkg::HFOV_W-1:0] half_fov_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_fov_reg <= bvcc_pkg::HALF_FOV_RESET;
        else if (cfg_valid && cfg_ready)
            half_fov_reg <= cfg_data;
    end

    // ------------------------------------------------------------------
    // stage 1: edge angles, viewer inside test, corner offsets
    // ------------------------------------------------------------------
    logic                   accept;
    logic [AB-1:0]          ang;
    logic                   inside_next;
    logic                   s1_valid_reg;
    logic                   s1_inside_reg;
    logic [AB-1:0]          s1_lo_reg;
    logic [AB-1:0]          s1_hi_reg;
    logic signed [DW-1:0]   s1_dxl_reg;
    logic signed [DW-1:0]   s1_dxr_reg;
    logic signed [DW-1:0]   s1_dyt_reg;
    logic signed [DW-1:0]   s1_dyb_reg;

    assign accept = start && !busy;
    assign ang    = AB'(item.view_angle);

    assign inside_next = (item.view_x >= item.box_left) && (item.view_x < item.box_right) &&
                         (item.view_y <= item.box_top) && (item.view_y > item.box_bottom);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inside_reg <= inside_next;
            s1_lo_reg     <= ang - AB'(half_fov_reg);
            s1_hi_reg     <= ang + AB'(half_fov_reg);
            s1_dxl_reg    <= DW'(item.box_left) - DW'(item.view_x);
            s1_dxr_reg    <= DW'(item.box_right) - DW'(item.view_x);
            s1_dyt_reg    <= DW'(item.box_top) - DW'(item.view_y);
            s1_dyb_reg    <= DW'(item.box_bottom) - DW'(item.view_y);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: edge directions from the sine table
    // ------------------------------------------------------------------
    logic signed [TW-1:0]   sin_lo;
    logic signed [TW-1:0]   cos_lo;
    logic signed [TW-1:0]   sin_hi;
    logic signed [TW-1:0]   cos_hi;
    logic                   s2_valid_reg;
    logic                   s2_inside_reg;
    logic signed [DW-1:0]   s2_dxl_reg;
    logic signed [DW-1:0]   s2_dxr_reg;
    logic signed [DW-1:0]   s2_dyt_reg;
    logic signed [DW-1:0]   s2_dyb_reg;
    logic signed [TW-1:0]   s2_ax_reg;
    logic signed [TW-1:0]   s2_ay_reg;
    logic signed [TW-1:0]   s2_bx_reg;
    logic signed [TW-1:0]   s2_by_reg;

    bvcc_sincos u_trig_lo (
        .angle   (s1_lo_reg),
        .sin_val (sin_lo),
        .cos_val (cos_lo)
    );

    bvcc_sincos u_trig_hi (
        .angle   (s1_hi_reg),
        .sin_val (sin_hi),
        .cos_val (cos_hi)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_inside_reg <= s1_inside_reg;
            s2_dxl_reg    <= s1_dxl_reg;
            s2_dxr_reg    <= s1_dxr_reg;
            s2_dyt_reg    <= s1_dyt_reg;
            s2_dyb_reg    <= s1_dyb_reg;
            s2_ax_reg     <= -cos_lo;
            s2_ay_reg     <= sin_lo;
            s2_bx_reg     <= cos_hi;
            s2_by_reg     <= -sin_hi;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: cross-product terms, one multiplier each
    // ------------------------------------------------------------------
    logic                   s3_valid_reg;
    logic                   s3_inside_reg;
    logic signed [PW-1:0]   s3_xl_ay_reg;
    logic signed [PW-1:0]   s3_xr_ay_reg;
    logic signed [PW-1:0]   s3_yt_ax_reg;
    logic signed [PW-1:0]   s3_yb_ax_reg;
    logic signed [PW-1:0]   s3_xl_by_reg;
    logic signed [PW-1:0]   s3_xr_by_reg;
    logic signed [PW-1:0]   s3_yt_bx_reg;
    logic signed [PW-1:0]   s3_yb_bx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_inside_reg <= s2_inside_reg;
            s3_xl_ay_reg  <= PW'(s2_dxl_reg) * PW'(s2_ay_reg);
            s3_xr_ay_reg  <= PW'(s2_dxr_reg) * PW'(s2_ay_reg);
            s3_yt_ax_reg  <= PW'(s2_dyt_reg) * PW'(s2_ax_reg);
            s3_yb_ax_reg  <= PW'(s2_dyb_reg) * PW'(s2_ax_reg);
            s3_xl_by_reg  <= PW'(s2_dxl_reg) * PW'(s2_by_reg);
            s3_xr_by_reg  <= PW'(s2_dxr_reg) * PW'(s2_by_reg);
            s3_yt_bx_reg  <= PW'(s2_dyt_reg) * PW'(s2_bx_reg);
            s3_yb_bx_reg  <= PW'(s2_dyb_reg) * PW'(s2_bx_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sign tests per corner, result register
    // ------------------------------------------------------------------
    logic signed [CW-1:0]   cr_lt_a;
    logic signed [CW-1:0]   cr_rt_a;
    logic signed [CW-1:0]   cr_lb_a;
    logic signed [CW-1:0]   cr_rb_a;
    logic signed [CW-1:0]   cr_lt_b;
    logic signed [CW-1:0]   cr_rt_b;
    logic signed [CW-1:0]   cr_lb_b;
    logic signed [CW-1:0]   cr_rb_b;
    logic                   cone_hit;
    logic                   out_valid_reg;
    bvcc_pkg::result_t      out_reg;

    assign cr_lt_a = CW'(s3_xl_ay_reg) - CW'(s3_yt_ax_reg);
    assign cr_rt_a = CW'(s3_xr_ay_reg) - CW'(s3_yt_ax_reg);
    assign cr_lb_a = CW'(s3_xl_ay_reg) - CW'(s3_yb_ax_reg);
    assign cr_rb_a = CW'(s3_xr_ay_reg) - CW'(s3_yb_ax_reg);
    assign cr_lt_b = CW'(s3_xl_by_reg) - CW'(s3_yt_bx_reg);
    assign cr_rt_b = CW'(s3_xr_by_reg) - CW'(s3_yt_bx_reg);
    assign cr_lb_b = CW'(s3_xl_by_reg) - CW'(s3_yb_bx_reg);
    assign cr_rb_b = CW'(s3_xr_by_reg) - CW'(s3_yb_bx_reg);

    // a corner is in the cone when it is strictly on the inner side of both edges
    assign cone_hit = (cr_lt_a[CW-1] && cr_lt_b[CW-1]) ||
                      (cr_rt_a[CW-1] && cr_rt_b[CW-1]) ||
                      (cr_lb_a[CW-1] && cr_lb_b[CW-1]) ||
                      (cr_rb_a[CW-1] && cr_rb_b[CW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            out_reg.visible       <= s3_inside_reg || cone_hit;
            out_reg.viewer_inside <= s3_inside_reg;
        end
    end

    assign done   = out_valid_reg;
    assign result = out_reg;

`ifndef NO_ASSERTIONS
    // every accepted box gives its result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted box produced no result after four cycles");

    // no result without a matching accepted box
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without a matching accepted box");

    // viewer inside always implies visible
    a_inside_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.viewer_inside) |-> result.visible)
        else $error("viewer_inside set while visible clear");
`endif

endmodule

// ----- tb/box_view_cone_cull_tb.sv -----
// ----------------------------------------------------------------------------
// box_view_cone_cull_tb
// Self-checking bench for the box view cone cull block. A scoreboard
// predicts visible/viewer_inside for every box taken, using its own
// sine table and exact cross products, and compares each done beat in
// order. Directed boxes cover edges, inverted boxes and extreme
// coordinates; random bursts with gaps run under several half_fov values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_view_cone_cull_tb;

    localparam int ANGLE_MASK = (1 << bvcc_pkg::ANGLE_BITS) - 1;
    localparam int DRAIN_CYCLES = 8;

    // visibility predictor and store of pending verdicts
    class cull_scoreboard;
        bvcc_pkg::result_t verdicts[$];
        longint  sine_mag[0:bvcc_pkg::QUARTER];
        int      errors;
        int      boxes_taken;
        int      verdicts_checked;
        int      visible_count;
        int      inside_count;

        function new();
            longint unsigned x;
            longint unsigned term;
            longint unsigned mag;
            longint          acc;
            int              r;
            int              k;
            // quarter-wave sine magnitudes, series in Q30
            for (r = 0; r <= bvcc_pkg::QUARTER; r++)
            begin
                x   = (longint'(r) * bvcc_pkg::PIH_Q30) >> (bvcc_pkg::ANGLE_BITS - 2);
                term = x;
                acc  = longint'(x);
                for (k = 1; k <= 6; k++)
                begin
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / longint'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                mag = (longint'(acc) + (64'd1 << (29 - bvcc_pkg::TRIG_FRAC_BITS)))
                      >> (30 - bvcc_pkg::TRIG_FRAC_BITS);
                if (mag > (64'd1 << bvcc_pkg::TRIG_FRAC_BITS))
                    mag = 64'd1 << bvcc_pkg::TRIG_FRAC_BITS;
                sine_mag[r] = longint'(mag);
            end
            errors           = 0;
            boxes_taken      = 0;
            verdicts_checked = 0;
            visible_count    = 0;
            inside_count     = 0;
        endfunction

        function longint wave_sin(int a);
            int     am;
            int     quad;
            int     off;
            longint m;
            am   = a & ANGLE_MASK;
            quad = (am >> (bvcc_pkg::ANGLE_BITS - 2)) & 3;
            off  = am & (bvcc_pkg::QUARTER - 1);
            m    = (quad & 1) ? sine_mag[bvcc_pkg::QUARTER - off] : sine_mag[off];
            return (quad & 2) ? -m : m;
        endfunction

        function longint wave_cos(int a);
            return wave_sin(a + bvcc_pkg::QUARTER);
        endfunction

        // strictly negative cross product against both edges
        function bit corner_in_cone(longint px, longint py, longint vx, longint vy,
                                    longint ax, longint ay, longint bx, longint by);
            longint ex;
            longint ey;
            ex = px - vx;
            ey = py - vy;
            return ((ex * ay - ey * ax) < 0) && ((ex * by - ey * bx) < 0);
        endfunction

        function void note_box(bvcc_pkg::item_t b, logic [bvcc_pkg::HFOV_W-1:0] hfov);
            bvcc_pkg::result_t v;
            longint  left;
            longint  right;
            longint  top;
            longint  bottom;
            longint  vx;
            longint  vy;
            longint  ax;
            longint  ay;
            longint  bx;
            longint  by;
            int      lo;
            int      hi;
            left   = longint'($signed(b.box_left));
            right  = longint'($signed(b.box_right));
            top    = longint'($signed(b.box_top));
            bottom = longint'($signed(b.box_bottom));
            vx     = longint'($signed(b.view_x));
            vy     = longint'($signed(b.view_y));
            lo     = (int'(b.view_angle) - int'(hfov)) & ANGLE_MASK;
            hi     = (int'(b.view_angle) + int'(hfov)) & ANGLE_MASK;
            if (vx >= left && vx < right && vy <= top && vy > bottom)
            begin
                v.visible       = 1'b1;
                v.viewer_inside = 1'b1;
            end
            else
            begin
                ax = -wave_cos(lo);
                ay = wave_sin(lo);
                bx = wave_cos(hi);
                by = -wave_sin(hi);
                v.viewer_inside = 1'b0;
                v.visible = corner_in_cone(left, top, vx, vy, ax, ay, bx, by)
                         || corner_in_cone(right, top, vx, vy, ax, ay, bx, by)
                         || corner_in_cone(left, bottom, vx, vy, ax, ay, bx, by)
                         || corner_in_cone(right, bottom, vx, vy, ax, ay, bx, by);
            end
            verdicts.push_back(v);
            boxes_taken++;
            if (v.visible)
                visible_count++;
            if (v.viewer_inside)
                inside_count++;
        endfunction

        function void check_result(bvcc_pkg::result_t got);
            bvcc_pkg::result_t want;
            if (verdicts.size() == 0)
            begin
                $error("result beat with no box pending: visible %0b viewer_inside %0b",
                       got.visible, got.viewer_inside);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            verdicts_checked++;
            if (got.visible !== want.visible)
            begin
                $error("visible mismatch: expected %0b, got %0b", want.visible, got.visible);
                errors++;
            end
            if (got.viewer_inside !== want.viewer_inside)
            begin
                $error("viewer_inside mismatch: expected %0b, got %0b",
                       want.viewer_inside, got.viewer_inside);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    bvcc_pkg::item_t               item;
    logic                          done;
    bvcc_pkg::result_t             result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bvcc_pkg::HFOV_W-1:0]   cfg_data;

    cull_scoreboard                sb;
    logic [bvcc_pkg::HFOV_W-1:0]   fov_setting;
    int                            settings_used;

    box_view_cone_cull u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watch result, box and config beats on each edge
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_box(item, fov_setting);
            if (cfg_valid && cfg_ready)
                fov_setting = cfg_data;
        end
    end

    function automatic logic signed [bvcc_pkg::COORD_W-1:0] clip16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[bvcc_pkg::COORD_W-1:0];
    endfunction

    function automatic bvcc_pkg::item_t make_box(int l, int r, int t, int b,
                                                 int vx, int vy, int ang);
        bvcc_pkg::item_t box;
        box.box_left   = clip16(l);
        box.box_right  = clip16(r);
        box.box_top    = clip16(t);
        box.box_bottom = clip16(b);
        box.view_x     = clip16(vx);
        box.view_y     = clip16(vy);
        box.view_angle = ang[9:0];
        return box;
    endfunction

    // mostly well-formed boxes near the viewer, some inside, inverted or noise
    function automatic bvcc_pkg::item_t random_box();
        bvcc_pkg::item_t box;
        int    vx;
        int    vy;
        int    cx;
        int    cy;
        int    w;
        int    h;
        int    span;
        int    ang;
        int    kind;
        vx   = int'($urandom_range(0, 65535)) - 32768;
        vy   = int'($urandom_range(0, 65535)) - 32768;
        ang  = int'($urandom_range(0, ANGLE_MASK));
        span = ($urandom_range(0, 3) == 0) ? 20 : 5000;
        kind = int'($urandom_range(0, 9));
        w    = int'($urandom_range(0, 800));
        h    = int'($urandom_range(0, 800));
        cx   = vx + int'($urandom_range(0, 2 * span)) - span;
        cy   = vy + int'($urandom_range(0, 2 * span)) - span;
        case (kind)
            0:
            begin
                box.box_left   = bvcc_pkg::COORD_W'($urandom);
                box.box_right  = bvcc_pkg::COORD_W'($urandom);
                box.box_top    = bvcc_pkg::COORD_W'($urandom);
                box.box_bottom = bvcc_pkg::COORD_W'($urandom);
                box.view_x     = bvcc_pkg::COORD_W'($urandom);
                box.view_y     = bvcc_pkg::COORD_W'($urandom);
                box.view_angle = 10'($urandom);
            end
            1, 2:
            begin
                w   = w + 1;
                h   = h + 1;
                cx  = vx - int'($urandom_range(0, w - 1));
                cy  = vy - int'($urandom_range(1, h));
                box = make_box(cx, cx + w, cy + h, cy, vx, vy, ang);
            end
            3:
            begin
                if ($urandom_range(0, 1) == 0)
                    box = make_box(cx + w, cx, cy + h, cy, vx, vy, ang);
                else
                    box = make_box(cx, cx + w, cy, cy + h, vx, vy, ang);
            end
            default:
                box = make_box(cx, cx + w, cy + h, cy, vx, vy, ang);
        endcase
        return box;
    endfunction

    // hold one box beat until it is taken; start stays high afterwards
    task automatic drive_box(input bvcc_pkg::item_t box);
        start <= 1'b1;
        item  <= box;
        @(posedge clk iff !busy);
    endtask

    // stop sending and wait for every pending verdict
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_fov(input logic [bvcc_pkg::HFOV_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk iff cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // random boxes in bursts with random gaps, noise on item while idle
    task automatic random_phase(input int count);
        int left_to_send;
        int burst;
        int i;
        left_to_send = count;
        while (left_to_send > 0)
        begin
            burst = int'($urandom_range(1, 16));
            for (i = 0; i < burst && left_to_send > 0; i++)
            begin
                drive_box(random_box());
                left_to_send--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                item  <= random_box();
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        drain();
    endtask

    task automatic directed_phase();
        bvcc_pkg::item_t boxes[$];
        int    a;
        // viewer on the inclusive left and top edges
        boxes.push_back(make_box(0, 10, 10, 0, 0, 10, 0));
        // viewer on the exclusive right edge, then the exclusive bottom edge
        boxes.push_back(make_box(0, 10, 10, 0, 10, 5, 0));
        boxes.push_back(make_box(0, 10, 10, 0, 5, 0, 512));
        // inverted boxes: equal edges and swapped edges
        boxes.push_back(make_box(5, 5, 10, 0, 5, 5, 0));
        boxes.push_back(make_box(0, 10, 5, 5, 5, 5, 256));
        boxes.push_back(make_box(20, 10, 30, 15, 0, 0, 64));
        boxes.push_back(make_box(10, 20, 15, 30, 0, 0, 64));
        // corners lying on an edge of the cone
        boxes.push_back(make_box(10, 20, 0, -5, 0, 0, 64));
        boxes.push_back(make_box(10, 20, 5, 0, 0, 0, 960));
        // extreme coordinates
        boxes.push_back(make_box(-32768, 32767, 32767, -32768, 32767, -32768, 384));
        boxes.push_back(make_box(-32768, 32767, 32767, -32768, -32768, 32767, 896));
        boxes.push_back(make_box(32767, 32767, 32767, 32767, -32768, -32768, 128));
        boxes.push_back(make_box(-32768, -32768, -32768, -32768, 32767, 32767, 640));
        boxes.push_back(make_box(-32768, 32767, 32767, -32768, 0, 0, 0));
        // one fixed box at positive x from the viewer, at every quadrant boundary of the angle
        foreach (boxes[j])
            drive_box(boxes[j]);
        for (a = 0; a < 8; a++)
            drive_box(make_box(100, 200, 50, -50, 0, 0, (a * 128 + ((a % 2) ? 127 : 0))));
        drive_box(make_box(-50, 50, -100, -200, 0, 0, ANGLE_MASK));
        drive_box(make_box(-50, 50, 200, 100, 0, 0, 255));
        drain();
    endtask

    initial
    begin
        sb            = new();
        settings_used = 1;
        fov_setting   = bvcc_pkg::HALF_FOV_RESET;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        item          <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of half_fov first
        directed_phase();
        random_phase(60);

        // extremes and a spread of half_fov values
        write_fov(8'd0);
        random_phase(80);
        write_fov(8'd255);
        random_phase(80);
        write_fov(8'd1);
        random_phase(70);
        write_fov(8'd128);
        random_phase(70);
        write_fov(8'd254);
        random_phase(70);
        repeat (2)
        begin
            write_fov(bvcc_pkg::HFOV_W'($urandom_range(0, 255)));
            random_phase(70);
        end
        write_fov(bvcc_pkg::HALF_FOV_RESET);
        random_phase(30);

        $display("covered %0d boxes under %0d half_fov settings, %0d verdicts checked",
                 sb.boxes_taken, settings_used, sb.verdicts_checked);
        $display("  %0d predicted visible, %0d with the viewer inside the box",
                 sb.visible_count, sb.inside_count);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
